// ===== src/atw_pkg.sv =====
// Shared types and constants of the ANSI text terminal writer.
`default_nettype none
package atw_pkg;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_SCROLL = 2'd1;
   localparam logic [1:0] ACT_MOVE   = 2'd2;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ESC     = 2'd1;
   localparam logic [1:0] PH_CSI     = 2'd2;

   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_M       = 8'h6D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [3:0] COL_WHITE  = 4'd7;
   localparam logic [3:0] COL_BLACK  = 4'd0;

   localparam logic [7:0] SGR_RESET  = 8'd0;
   localparam logic [7:0] SGR_BOLD   = 8'd1;
   localparam logic [7:0] SGR_INVERT = 8'd7;
   localparam logic [7:0] SGR_FG_LO  = 8'd30;
   localparam logic [7:0] SGR_FG_HI  = 8'd37;
   localparam logic [7:0] SGR_FG_DEF = 8'd39;
   localparam logic [7:0] SGR_BG_LO  = 8'd40;
   localparam logic [7:0] SGR_BG_HI  = 8'd47;
   localparam logic [7:0] SGR_BG_DEF = 8'd49;

   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_WRITE   = 3'd2;
   localparam logic [2:0] OP_SCROLL  = 3'd3;
   localparam logic [2:0] OP_MOVE    = 3'd4;
   localparam logic [2:0] OP_SGR     = 3'd5;

   typedef struct packed {
      logic [2:0] op;
   } atw_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_parse;
      logic write_emits;
      logic tab_more;
      logic sgr_go;
      logic scroll_need;
      logic sgr_last;
   } atw_status_type;

endpackage
`default_nettype wire

// ===== src/atw_ifs.sv =====
// Valid/ready channel interfaces for input bytes and result words.
`default_nettype none
interface atw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

interface atw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [11:0] cell_index;
   logic [7:0]  glyph;
   logic [3:0]  fore_colour;
   logic [3:0]  back_colour;
   logic        last;
   modport source (output valid, output action, output cell_index, output glyph,
                   output fore_colour, output back_colour, output last, input ready);
   modport sink (input valid, input action, input cell_index, input glyph,
                 input fore_colour, input back_colour, input last, output ready);
endinterface
`default_nettype wire

// ===== src/atw_ctrl.sv =====
// Sequencing state machine of the terminal writer.
`default_nettype none
module atw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire atw_pkg::atw_status_type status,
   output atw_pkg::atw_cmd_type         cmd
);
   import atw_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WRITE  = 3'd1;
   localparam logic [2:0] S_SCROLL = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_SGR    = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (!status.write_emits || status.out_free) begin
               cmd.op = OP_WRITE;
               if (status.is_parse) begin
                  state_in = status.sgr_go ? S_SGR : S_IDLE;
               end else if (!status.tab_more) begin
                  state_in = S_SCROLL;
               end
            end
         end
         S_SCROLL: begin
            if (!status.scroll_need) begin
               state_in = S_MOVE;
            end else if (status.out_free) begin
               cmd.op   = OP_SCROLL;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (status.out_free) begin
               cmd.op   = OP_MOVE;
               state_in = S_IDLE;
            end
         end
         S_SGR: begin
            cmd.op = OP_SGR;
            if (status.sgr_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/atw_datapath.sv =====
// Cursor, colour, escape parser state and result register of the terminal writer.
`default_nettype none
module atw_datapath #(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 30,
   parameter int MAX_PARAMS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire atw_pkg::atw_cmd_type    cmd,
   output atw_pkg::atw_status_type      status,
   input  wire logic [7:0]              req_char_byte,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_action,
   output logic [11:0]                  rsp_cell_index,
   output logic [7:0]                   rsp_glyph,
   output logic [3:0]                   rsp_fore_colour,
   output logic [3:0]                   rsp_back_colour,
   output logic                         rsp_last
);
   import atw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int CELL_W = $clog2(2 * CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int SLOT_W = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam logic [CELL_W-1:0] CELLS_C   = CELL_W'(CELLS);
   localparam logic [CELL_W-1:0] COLS_C    = CELL_W'(COLUMNS);
   localparam logic [CELL_W-1:0] BOTTOM_C  = CELL_W'(CELLS - COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [SLOT_W-1:0] MAX_SLOT  = SLOT_W'(MAX_PARAMS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_PARAMS - 1);

   logic [7:0]        byte_ff;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [3:0]        fore_ff, fore_in, back_ff, back_in;
   logic [1:0]        phase_ff, phase_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0]  walk_ff, walk_in;
   logic [7:0]        params_ff [MAX_PARAMS];

   logic              out_free, load_out, clear_params, digit_wr;
   logic [1:0]        out_action;
   logic [CELL_W-1:0] out_cell, cursor_inc, cursor_dec, col_ext;
   logic [CELL_W+11:0] cell_wide;
   logic [7:0]        out_glyph, rd_val;
   logic [3:0]        out_fore, out_back;
   logic              out_last;
   logic [IDX_W-1:0]  rd_idx;
   logic [11:0]       digit_mul;
   logic [7:0]        digit_val;
   logic              is_digit;
   logic [COL_W-1:0]  col_inc, col_dec;

   assign out_free   = !rsp_valid || rsp_ready;
   assign cursor_inc = cursor_ff + CELL_W'(1);
   assign cursor_dec = cursor_ff - CELL_W'(1);
   assign col_ext    = CELL_W'(col_ff);
   assign col_inc    = (col_ff == LAST_COL) ? '0 : col_ff + COL_W'(1);
   assign col_dec    = (col_ff == '0) ? LAST_COL : col_ff - COL_W'(1);
   assign is_digit   = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign rd_idx     = (cmd.op == OP_SGR) ? walk_ff : slot_ff[IDX_W-1:0];
   assign rd_val     = params_ff[rd_idx];
   assign digit_mul  = {4'd0, rd_val} * 12'd10 + {4'd0, byte_ff - CH_ZERO};
   assign digit_val  = (digit_mul > 12'd255) ? 8'd255 : digit_mul[7:0];

   always_comb begin
      status.out_free    = out_free;
      status.is_parse    = (phase_ff != PH_IDLE);
      status.write_emits = (phase_ff == PH_IDLE) && (byte_ff != CH_ESC) &&
                           (byte_ff != CH_LF) && (byte_ff != CH_CR) &&
                           ((byte_ff != CH_BS) || (cursor_ff != '0));
      status.tab_more    = (byte_ff == CH_TAB) && (cursor_inc[1:0] != 2'd0) &&
                           (cursor_inc < CELLS_C);
      status.sgr_go      = (phase_ff == PH_CSI) && (byte_ff == CH_M);
      status.scroll_need = (cursor_ff >= CELLS_C);
      status.sgr_last    = ({{SLOT_W{1'b0}}, walk_ff} == {{IDX_W{1'b0}}, slot_ff}) ||
                           (walk_ff == LAST_IDX);
   end

   always_comb begin
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      fore_in      = fore_ff;
      back_in      = back_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      walk_in      = walk_ff;
      clear_params = 1'b0;
      digit_wr     = 1'b0;
      load_out     = 1'b0;
      out_action   = ACT_WRITE;
      out_cell     = cursor_ff;
      out_glyph    = byte_ff;
      out_fore     = fore_ff;
      out_back     = back_ff;
      out_last     = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            walk_in = '0;
         end
         OP_WRITE: begin
            if (phase_ff == PH_ESC) begin
               if (byte_ff == CH_LBRACK) begin
                  phase_in     = PH_CSI;
                  slot_in      = '0;
                  clear_params = 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (phase_ff == PH_CSI) begin
               if (is_digit) begin
                  digit_wr = (slot_ff < MAX_SLOT);
               end else if (byte_ff == CH_SEMI) begin
                  if (slot_ff < MAX_SLOT) begin
                     slot_in = slot_ff + SLOT_W'(1);
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (phase_ff != PH_IDLE) begin
               phase_in = PH_IDLE;
            end else if (byte_ff == CH_ESC) begin
               phase_in = PH_ESC;
            end else if (byte_ff == CH_LF) begin
               cursor_in = cursor_ff - col_ext + COLS_C;
               col_in    = '0;
            end else if (byte_ff == CH_CR) begin
               cursor_in = cursor_ff - col_ext;
               col_in    = '0;
            end else if (byte_ff == CH_BS) begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_dec;
                  col_in    = col_dec;
                  load_out  = 1'b1;
                  out_cell  = cursor_dec;
                  out_glyph = CH_SPACE;
               end
            end else begin
               cursor_in = cursor_inc;
               col_in    = col_inc;
               load_out  = 1'b1;
               if (byte_ff == CH_TAB) begin
                  out_glyph = CH_SPACE;
               end
            end
         end
         OP_SCROLL: begin
            cursor_in  = cursor_ff - COLS_C;
            load_out   = 1'b1;
            out_action = ACT_SCROLL;
            out_cell   = BOTTOM_C;
            out_glyph  = CH_SPACE;
         end
         OP_MOVE: begin
            load_out   = 1'b1;
            out_action = ACT_MOVE;
            out_glyph  = 8'd0;
            out_fore   = 4'd0;
            out_back   = 4'd0;
            out_last   = 1'b1;
         end
         OP_SGR: begin
            walk_in = walk_ff + IDX_W'(1);
            if (rd_val == SGR_RESET) begin
               fore_in = COL_WHITE;
               back_in = COL_BLACK;
            end else if (rd_val == SGR_BOLD) begin
               fore_in = fore_ff | 4'd8;
            end else if (rd_val == SGR_INVERT) begin
               fore_in = back_ff;
               back_in = fore_ff;
            end else if (rd_val == SGR_FG_DEF) begin
               fore_in = {fore_ff[3], COL_WHITE[2:0]};
            end else if (rd_val == SGR_BG_DEF) begin
               back_in = {back_ff[3], COL_BLACK[2:0]};
            end else if ((rd_val >= SGR_FG_LO) && (rd_val <= SGR_FG_HI)) begin
               fore_in = {fore_ff[3], 3'(rd_val - SGR_FG_LO)};
            end else if ((rd_val >= SGR_BG_LO) && (rd_val <= SGR_BG_HI)) begin
               back_in = {back_ff[3], 3'(rd_val - SGR_BG_LO)};
            end
         end
         default: begin
         end
      endcase
   end

   assign cell_wide = {12'd0, out_cell};

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         col_ff    <= '0;
         fore_ff   <= COL_WHITE;
         back_ff   <= COL_BLACK;
         phase_ff  <= PH_IDLE;
         slot_ff   <= '0;
         walk_ff   <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < MAX_PARAMS; i++) begin
            params_ff[i] <= 8'd0;
         end
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         fore_ff   <= fore_in;
         back_ff   <= back_in;
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         walk_ff   <= walk_in;
         if (load_out) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         if (clear_params) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
               params_ff[i] <= 8'd0;
            end
         end else if (digit_wr) begin
            params_ff[rd_idx] <= digit_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         byte_ff <= req_char_byte;
      end
      if (load_out) begin
         rsp_action      <= out_action;
         rsp_cell_index  <= cell_wide[11:0];
         rsp_glyph       <= out_glyph;
         rsp_fore_colour <= out_fore;
         rsp_back_colour <= out_back;
         rsp_last        <= out_last;
      end
   end
endmodule
`default_nettype wire

// ===== src/ansi_text_terminal_writer_top.sv =====
// Top level of the ANSI text terminal writer.
// The block takes one character byte per word on req_chan and gives cell
// writes, an optional scroll of one row and a final cursor move on rsp_chan,
// the last of these words marked by last. Bytes inside an ESC [ ... m
// sequence, and the byte after ESC, give no words; ESC itself gives a move.
// One byte is handled at a time: it is taken, then its result words are given
// in turn while the receiver keeps up. A closing m walks the stored
// parameters one per cycle, up to MAX_PARAMS of them.
// The next byte is taken as soon as the last word sits in the output
// register, even while the receiver has not yet taken it.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset puts the cursor at cell 0, white on black, the
// parser idle and all parameters at zero.
`default_nettype none
module ansi_text_terminal_writer_top #(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 30,
   parameter int MAX_PARAMS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   atw_req_if.sink   req_chan,
   atw_rsp_if.source rsp_chan
);
   import atw_pkg::*;

   atw_cmd_type    cmd;
   atw_status_type status;

   atw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   atw_datapath #(
      .COLUMNS    (COLUMNS),
      .ROWS       (ROWS),
      .MAX_PARAMS (MAX_PARAMS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_char_byte   (req_chan.char_byte),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_action      (rsp_chan.action),
      .rsp_cell_index  (rsp_chan.cell_index),
      .rsp_glyph       (rsp_chan.glyph),
      .rsp_fore_colour (rsp_chan.fore_colour),
      .rsp_back_colour (rsp_chan.back_colour),
      .rsp_last        (rsp_chan.last)
   );
endmodule
`default_nettype wire

// ===== test/tb_ifs_note.sv =====
// Testbench helper types for the ANSI text terminal writer checks.
package tb_atw_pkg;
   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] cell_index;
      logic [7:0]  glyph;
      logic [3:0]  fore_colour;
      logic [3:0]  back_colour;
      logic        last;
   } screen_op_type;
endpackage

// ===== test/tb.sv =====
// Testbench of the ANSI text terminal writer: predicted screen operations against the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import atw_pkg::*;
   import tb_atw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS = 30;
   localparam int MAX_PARAMS = 16;
   localparam int CELLS = COLUMNS * ROWS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   atw_req_if req_chan ();
   atw_rsp_if rsp_chan ();

   ansi_text_terminal_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS), .MAX_PARAMS(MAX_PARAMS))
      dut (.clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   // Predictor state.
   int unsigned cursor;
   logic [3:0] fore, back;
   logic [1:0] phase;
   int unsigned slot;
   int unsigned params[MAX_PARAMS];
   screen_op_type pending_ops[$];
   int errors = 0;
   int words_seen = 0;
   int bytes_sent = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic void push_op(input logic [1:0] act, input int unsigned cell_no,
                                   input logic [7:0] g, input logic [3:0] f,
                                   input logic [3:0] b);
      screen_op_type w;
      w.action = act;
      w.cell_index = cell_no[11:0];
      w.glyph = g;
      w.fore_colour = f;
      w.back_colour = b;
      w.last = 1'b0;
      pending_ops.push_back(w);
   endfunction

   function automatic void apply_sgr_code(input int unsigned code);
      logic [3:0] t;
      if (code == SGR_RESET) begin
         fore = COL_WHITE;
         back = COL_BLACK;
      end else if (code == SGR_BOLD) begin
         fore[3] = 1'b1;
      end else if (code == SGR_INVERT) begin
         t = back;
         back = fore;
         fore = t;
      end else if (code == SGR_FG_DEF) begin
         fore = {fore[3], COL_WHITE[2:0]};
      end else if (code == SGR_BG_DEF) begin
         back = {back[3], COL_BLACK[2:0]};
      end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
         fore = {fore[3], 3'(code - SGR_FG_LO)};
      end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
         back = {back[3], 3'(code - SGR_BG_LO)};
      end
   endfunction

   function automatic void take_parser_byte(input logic [7:0] c);
      int unsigned v;
      if (phase == PH_ESC) begin
         if (c == CH_LBRACK) begin
            phase = PH_CSI;
            slot = 0;
            foreach (params[i]) params[i] = 0;
         end else begin
            phase = PH_IDLE;
         end
      end else if (phase == PH_CSI) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            if (slot < MAX_PARAMS) begin
               v = params[slot] * 10 + (c - CH_ZERO);
               params[slot] = v > 255 ? 255 : v;
            end
         end else if (c == CH_SEMI) begin
            if (slot < MAX_PARAMS) slot++;
         end else begin
            if (c == CH_M)
               for (int i = 0; i <= slot && i < MAX_PARAMS; i++) apply_sgr_code(params[i]);
            phase = PH_IDLE;
         end
      end else begin
         phase = PH_IDLE;
      end
   endfunction

   function automatic void predict_terminal(input logic [7:0] c);
      screen_op_type w;
      if (phase != PH_IDLE) begin
         take_parser_byte(c);
         return;
      end
      if (c == CH_ESC) begin
         phase = PH_ESC;
      end else if (c == CH_LF) begin
         cursor += COLUMNS;
         cursor -= cursor % COLUMNS;
      end else if (c == CH_CR) begin
         cursor -= cursor % COLUMNS;
      end else if (c == CH_BS) begin
         if (cursor > 0) begin
            cursor--;
            push_op(ACT_WRITE, cursor, CH_SPACE, fore, back);
         end
      end else if (c == CH_TAB) begin
         do begin
            push_op(ACT_WRITE, cursor, CH_SPACE, fore, back);
            cursor++;
         end while ((cursor % 4) != 0 && cursor < CELLS);
      end else begin
         push_op(ACT_WRITE, cursor, c, fore, back);
         cursor++;
      end
      if (cursor >= CELLS) begin
         cursor -= COLUMNS;
         push_op(ACT_SCROLL, CELLS - COLUMNS, CH_SPACE, fore, back);
      end
      push_op(ACT_MOVE, cursor, 8'h00, 4'h0, 4'h0);
      w = pending_ops.pop_back();
      w.last = 1'b1;
      pending_ops.push_back(w);
   endfunction

   function automatic int unsigned random_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   bit quiet_phase = 1'b0;

   // Called at a falling edge; returns at the falling edge after the word is taken.
   // Valid stays high between back-to-back words and drops only across a gap.
   task automatic send_byte(input logic [7:0] c);
      int unsigned gap;
      gap = quiet_phase ? 0 : random_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.char_byte <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_terminal(c);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Receiver stalls at random.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 40) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(5, 30)) @(negedge clock);
         end else begin
            rsp_chan.ready <= quiet_phase ? 1'b1 : ($urandom_range(0, 9) < 7);
         end
      end
   end

   always @(posedge clock) begin
      screen_op_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         words_seen++;
         if (pending_ops.size() == 0) begin
            report($sformatf("unexpected word action %0d cell %0d",
                             rsp_chan.action, rsp_chan.cell_index));
         end else begin
            w = pending_ops.pop_front();
            if (rsp_chan.action !== w.action)
               report($sformatf("action %0d, want %0d", rsp_chan.action, w.action));
            if (rsp_chan.cell_index !== w.cell_index)
               report($sformatf("cell %0d, want %0d", rsp_chan.cell_index, w.cell_index));
            if (rsp_chan.glyph !== w.glyph)
               report($sformatf("glyph %h, want %h", rsp_chan.glyph, w.glyph));
            if (rsp_chan.fore_colour !== w.fore_colour)
               report($sformatf("fore %h, want %h", rsp_chan.fore_colour, w.fore_colour));
            if (rsp_chan.back_colour !== w.back_colour)
               report($sformatf("back %h, want %h", rsp_chan.back_colour, w.back_colour));
            if (rsp_chan.last !== w.last)
               report($sformatf("last %b, want %b", rsp_chan.last, w.last));
         end
      end
   end

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic send_sgr(input string body);
      send_byte(CH_ESC);
      send_byte(CH_LBRACK);
      send_text(body);
      send_byte(CH_M);
   endtask

   task automatic test_control_bytes();
      send_byte(CH_BS);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_TAB);
      send_byte(CH_BS);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(8'h7F);
   endtask

   task automatic test_sgr_codes();
      send_sgr("1;31;42");
      send_byte("A");
      send_sgr("7;39;49");
      send_byte("B");
      send_sgr("0;999;0;30;37;40;47;5;1;2;3;4;5;6;7;8;9;1");
      send_byte("C");
      send_sgr("");
      send_byte(CH_ESC);
      send_byte("x");
      send_byte(CH_ESC);
      send_byte(CH_LBRACK);
      send_text("31H");
      send_byte("D");
   endtask

   task automatic test_scroll_edges();
      // Fill to the bottom row so that newline and tab both scroll.
      quiet_phase = 1'b1;
      repeat (ROWS) send_byte(CH_LF);
      quiet_phase = 1'b0;
      repeat (COLUMNS - 2) send_byte("z");
      send_byte(CH_TAB);
      send_byte(CH_LF);
      send_byte(CH_CR);
   endtask

   task automatic test_random_stream();
      int unsigned k, n;
      string digits;
      for (int i = 0; i < 55; i++) begin
         k = $urandom_range(0, 9);
         if (k < 3) begin
            n = $urandom_range(1, 4);
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            for (int j = 0; j < n; j++) begin
               if (j) send_byte(CH_SEMI);
               digits = $sformatf("%0d", $urandom_range(0, 9) < 7 ?
                                   $urandom_range(30, 49) : $urandom_range(0, 300));
               send_text(digits);
            end
            send_byte($urandom_range(0, 9) ? CH_M : 8'($urandom_range(64, 126)));
         end else if (k == 3) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (k == 4) begin
            case ($urandom_range(0, 3))
               0: send_byte(CH_LF);
               1: send_byte(CH_CR);
               2: send_byte(CH_BS);
               default: send_byte(CH_TAB);
            endcase
         end else begin
            send_byte(8'($urandom_range(32, 126)));
         end
      end
   endtask

   initial begin
      cursor = 0;
      fore = COL_WHITE;
      back = COL_BLACK;
      phase = PH_IDLE;
      slot = 0;
      foreach (params[i]) params[i] = 0;
      req_chan.valid = 1'b0;
      req_chan.char_byte = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_control_bytes();
      test_sgr_codes();
      test_scroll_edges();
      test_random_stream();
      req_chan.valid <= 1'b0;
      while (pending_ops.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Run covered %0d input bytes and %0d result words,", bytes_sent, words_seen);
      $display("including SGR sequences, control bytes and screen scrolls.");
      if (errors == 0 && pending_ops.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule
